/* hw/rtl/obiq_pkg.sv */
// shared types and local oscillator tables for the one-bit iq upconverter
`timescale 1ns / 1ps

package obiq_pkg;

   // index into the four-phase local oscillator
   typedef logic [1:0] lo_idx_type;

   // one lo index for each of the four samples of a word
   typedef lo_idx_type [3:0] lo_idx_set_type;

   localparam int SAMPLES_PER_WORD = 4;
   localparam int STEP_REG_WIDTH   = 34;

   // four-phase 1-bit sin and cos, bit n is the value at lo index n
   localparam logic [3:0] LO_SIN = 4'b0011;
   localparam logic [3:0] LO_COS = 4'b1001;

   function automatic logic lo_sin(input lo_idx_type idx);
      return LO_SIN[idx];
   endfunction

   function automatic logic lo_cos(input lo_idx_type idx);
      return LO_COS[idx];
   endfunction

endpackage

/* hw/rtl/one_bit_iq_if_upconverter.sv */
// top level of the one-bit iq to if digital upconverter
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_in_byte[7:0], req_phase_restart
// rsp       out        rsp_valid/rsp_stall  rsp_out_byte[7:0]
// csr       in         csr_wr_en            csr_wr_data[33:0] (phase step)
//
// one input word per cycle while req is not stalled; a word that completes a pair shows its output
// word in the cycle after acceptance, from the result register
// the four sample phases come from the word's start phase and three parallel adds of step multiples
// reset (synchronous) clears phase, pairing, step and the result valid
// req is stalled only while a result is held by rsp_stall

module one_bit_iq_if_upconverter #(
   parameter int PHASE_FRAC_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic [obiq_pkg::STEP_REG_WIDTH-1:0] csr_wr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_phase_restart,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte
);
   import obiq_pkg::*;

   // phase is in quarter cycles, two integer bits above the fraction
   localparam int PW = PHASE_FRAC_BITS + 2;

   // step multiples, precomputed at configuration time
   logic [PW-1:0] step_w;
   logic [PW-1:0] step1_ff;
   logic [PW-1:0] step2_ff;
   logic [PW-1:0] step3_ff;
   logic [PW-1:0] step4;

   // running state
   logic [PW-1:0] phase_ff;
   logic [PW-1:0] phase_in;
   logic          second_half_ff;
   logic          second_half_in;
   logic [3:0]    first_nibble_ff;
   logic [3:0]    first_nibble_in;

   // result register
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [7:0]    rsp_out_byte_ff;
   logic [7:0]    rsp_out_byte_in;

   // per-word datapath
   logic           accept;
   logic [PW-1:0]  base_phase;
   logic           base_half;
   logic [3:0]     base_first;
   logic [PW-1:0]  ph1;
   logic [PW-1:0]  ph2;
   logic [PW-1:0]  ph3;
   lo_idx_set_type lo_idx;
   logic [3:0]     nibble;

   // step bits above the phase width are dropped, a narrower step is zero extended
   assign step_w = PW'(csr_wr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         step1_ff <= '0;
         step2_ff <= '0;
         step3_ff <= '0;
      end else if (csr_wr_en) begin
         step1_ff <= step_w;
         step2_ff <= step_w << 1;
         step3_ff <= step_w + (step_w << 1);
      end
   end

   assign step4 = step1_ff << 2;

   // stall only while the held result is not taken
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // restart clears phase and pairing before this word
   always_comb begin
      if (req_phase_restart) begin
         base_phase = '0;
         base_half  = 1'b0;
         base_first = '0;
      end else begin
         base_phase = phase_ff;
         base_half  = second_half_ff;
         base_first = first_nibble_ff;
      end
   end

   // sample phases 1 to 3, each one add from the word's start phase, wrapping mod 4.0
   assign ph1 = base_phase + step1_ff;
   assign ph2 = base_phase + step2_ff;
   assign ph3 = base_phase + step3_ff;

   assign lo_idx[0] = base_phase[PW-1 -: 2];
   assign lo_idx[1] = ph1[PW-1 -: 2];
   assign lo_idx[2] = ph2[PW-1 -: 2];
   assign lo_idx[3] = ph3[PW-1 -: 2];

   obiq_mixer u_mixer (
      .in_byte (req_in_byte),
      .lo_idx  (lo_idx),
      .nibble  (nibble)
   );

   always_comb begin
      phase_in        = phase_ff;
      second_half_in  = second_half_ff;
      first_nibble_in = first_nibble_ff;
      rsp_out_byte_in = rsp_out_byte_ff;
      // a held result stays until taken
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      if (accept) begin
         phase_in = base_phase + step4;
         if (base_half) begin
            // second word of a pair: emit first nibble low, this nibble high
            second_half_in  = 1'b0;
            first_nibble_in = '0;
            rsp_out_byte_in = {nibble, base_first};
            rsp_valid_in    = 1'b1;
         end else begin
            // first word of a pair: hold its nibble
            second_half_in  = 1'b1;
            first_nibble_in = nibble;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= '0;
         second_half_ff  <= 1'b0;
         first_nibble_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         second_half_ff  <= second_half_in;
         first_nibble_ff <= first_nibble_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // output payload needs no reset
   always_ff @(posedge clock) begin
      rsp_out_byte_ff <= rsp_out_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;

endmodule

/* hw/rtl/obiq_mixer.sv */
// mixes the four iq pairs of one word with the 1-bit lo into a nibble
`timescale 1ns / 1ps

module obiq_mixer (
   input  logic [7:0]               in_byte,
   input  obiq_pkg::lo_idx_set_type lo_idx,
   output logic [3:0]               nibble
);
   import obiq_pkg::*;

   always_comb begin
      for (int k = 0; k < SAMPLES_PER_WORD; k++) begin
         // pair k: i in bit 7-2k, q in bit 6-2k, sample k lands in bit k
         nibble[k] = (in_byte[7 - 2 * k] ^ lo_sin(lo_idx[k]))
                   | (in_byte[6 - 2 * k] ^ lo_cos(lo_idx[k]));
      end
   end

endmodule

/* test/one_bit_iq_if_upconverter_tb.sv */
// self-checking testbench for the one-bit iq to if upconverter
`timescale 1ns / 1ps

module one_bit_iq_if_upconverter_tb;

   // phase format of the instance under test: 32 fraction bits, 34-bit accumulator
   localparam int FRAC_BITS = 32;

   // four-phase 1-bit local oscillator, bit n is the value at lo index n
   localparam logic [3:0] SIN_PATTERN = 4'b0011;
   localparam logic [3:0] COS_PATTERN = 4'b1001;

   // largest step and quarter-cycle step of the step register
   localparam logic [33:0] STEP_MAX     = 34'h3_FFFF_FFFF;
   localparam logic [33:0] QUARTER_STEP = 34'h1_0000_0000;

   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 400000;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [33:0] csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_phase_restart;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;

   // predictor state: phase accumulator, pairing flag, held nibble, step
   logic [33:0] pred_phase;
   logic        half_pending;
   logic [3:0]  held_nibble;
   logic [33:0] lo_step;

   // output words still owed by the block, oldest first
   logic [7:0]  pending_out_bytes[$];
   logic [7:0]  want_byte;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   // sender burst shaping
   int          gap_max = 0;
   int          burst_max = 1;
   int          burst_left = 0;

   // receiver stall pattern: alternating stall and free runs
   int          stall_max = 0;
   int          free_max = 1;
   int          stall_run_left = 0;
   logic        stall_on = 1'b0;

   one_bit_iq_if_upconverter #(
      .PHASE_FRAC_BITS(FRAC_BITS)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_phase_restart (req_phase_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver back-pressure: runs of stall and free cycles of random length
   always @(posedge clock) begin
      if (stall_run_left == 0) begin
         stall_on = !stall_on && (stall_max != 0);
         stall_run_left = stall_on ? $urandom_range(1, stall_max) : $urandom_range(1, free_max);
      end
      stall_run_left--;
      rsp_stall <= stall_on;
   end

   // compare every accepted output word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_out_bytes.size() == 0) begin
            $error("out_byte: no word expected, got %02h", rsp_out_byte);
            mismatch_count++;
         end else begin
            want_byte = pending_out_bytes.pop_front();
            if (rsp_out_byte !== want_byte) begin
               $error("out_byte: expected %02h, got %02h", want_byte, rsp_out_byte);
               mismatch_count++;
            end
         end
      end
   end

   // predict one input word: mix four samples, pair nibbles into an output word
   function automatic void mix_word(input logic [7:0] in_word, input logic restart);
      logic [3:0] nib;
      logic [1:0] idx;
      logic       ibit;
      logic       qbit;
      if (restart) begin
         // restart drops any held first half and zeroes the phase
         pred_phase   = '0;
         half_pending = 1'b0;
         held_nibble  = '0;
      end
      for (int k = 0; k < 4; k++) begin
         idx    = pred_phase[FRAC_BITS +: 2];
         ibit   = in_word[7 - 2 * k];
         qbit   = in_word[6 - 2 * k];
         nib[k] = (ibit ^ SIN_PATTERN[idx]) | (qbit ^ COS_PATTERN[idx]);
         // 34-bit add wraps at four quarter cycles
         pred_phase = pred_phase + lo_step;
      end
      if (!half_pending) begin
         held_nibble  = nib;
         half_pending = 1'b1;
      end else begin
         pending_out_bytes.push_back({nib, held_nibble});
         half_pending = 1'b0;
         held_nibble  = '0;
      end
   endfunction

   // hand one word to the block, honoring the burst and gap pattern
   task automatic send_word(input logic [7:0] in_word, input logic restart);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         burst_left = $urandom_range(1, burst_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_in_byte       <= in_word;
      req_phase_restart <= restart;
      do @(posedge clock); while (req_stall);
      mix_word(in_word, restart);
   endtask

   // idle the sender, wait for all owed words, then let the block settle
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_out_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_phase_step(input logic [33:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      lo_step = value;
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input int gaps, input int bursts, input int stalls, input int frees);
      gap_max    = gaps;
      burst_max  = bursts;
      stall_max  = stalls;
      free_max   = frees;
      burst_left = 0;
   endtask

   // zero step: lo sits at index 0, all-zero and all-one words
   task automatic test_zero_step();
      write_phase_step('0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
   endtask

   // quarter-cycle step walks the lo through all four indexes every word
   task automatic test_lo_phases();
      write_phase_step(QUARTER_STEP);
      send_word(8'hAA, 1'b0);
      send_word(8'h55, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hC3, 1'b0);
      send_word(8'h3C, 1'b0);
   endtask

   // restart with a held first half drops it; restart on a pair start just rephases
   task automatic test_restart();
      send_word(8'h12, 1'b1);
      send_word(8'h34, 1'b0);
      send_word(8'h9B, 1'b0);
      send_word(8'h56, 1'b1);
      send_word(8'h78, 1'b0);
      send_word(8'hE1, 1'b1);
   endtask

   // largest step wraps just short of a full cycle; fractional step accumulates
   task automatic test_step_extremes();
      write_phase_step(STEP_MAX);
      send_word(8'h5A, 1'b1);
      send_word(8'hA5, 1'b0);
      send_word(8'hF0, 1'b0);
      send_word(8'h0F, 1'b0);
      write_phase_step(34'h0_8000_0001);
      send_word(8'h69, 1'b1);
      send_word(8'h96, 1'b0);
      write_phase_step(34'h3_0000_0000);
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b0);
   endtask

   // one setting of the step with random words and occasional restarts
   task automatic run_random_phase(input logic [33:0] step, input int count);
      write_phase_step(step);
      for (int n = 0; n < count; n++)
         send_word(8'($urandom), ($urandom_range(0, 19) == 0));
   endtask

   // sweep step settings with mixed idling on both sides
   task automatic test_random_steps();
      set_idling(6, 8, 6, 10);
      run_random_phase(STEP_MAX, 150);
      run_random_phase('0, 150);
      run_random_phase(34'h0_0000_0001, 150);
      set_idling(10, 4, 3, 4);
      run_random_phase(34'h2_0000_0000, 150);
      run_random_phase(34'($urandom) | (34'($urandom_range(0, 3)) << 32), 150);
      run_random_phase({2'b10, 32'h5555_5555}, 150);
      set_idling(3, 16, 8, 20);
      run_random_phase({2'b01, 32'hAAAA_AAAA}, 150);
      run_random_phase(34'($urandom) | (34'($urandom_range(0, 3)) << 32), 150);
   endtask

   // back-to-back words with the receiver always ready
   task automatic test_full_rate();
      set_idling(0, 1, 0, 1);
      run_random_phase(34'($urandom) | (34'($urandom_range(0, 3)) << 32), 150);
      run_random_phase(QUARTER_STEP, 150);
   endtask

   // long receiver stalls, first against a sender that never pauses, then against one with short gaps
   task automatic test_heavy_stall();
      set_idling(0, 1, 12, 3);
      run_random_phase(34'($urandom) | (34'($urandom_range(0, 3)) << 32), 150);
      set_idling(2, 3, 12, 2);
      run_random_phase(STEP_MAX, 150);
   endtask

   initial begin
      // known values on every input from time zero
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_valid         = 1'b0;
      req_in_byte       = '0;
      req_phase_restart = 1'b0;

      // predictor starts in the reset state
      pred_phase   = '0;
      half_pending = 1'b0;
      held_nibble  = '0;
      lo_step      = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part runs at full rate with a lightly stalling receiver
      set_idling(0, 1, 2, 3);
      test_zero_step();
      test_lo_phases();
      test_restart();
      test_step_extremes();

      test_random_steps();
      test_full_rate();
      test_heavy_stall();

      // wait for the last owed words, then let the pipeline drain
      req_valid <= 1'b0;
      while (pending_out_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_out_bytes.size() != 0) begin
         $error("out_byte: %0d expected words never arrived", pending_out_bytes.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
